// File: rtl/rpf_pkg.sv
// rpf_pkg: shared types and constants for the RANSAC plane fit unit.
// Holds the transaction payload structs, action codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package rpf_pkg;

  localparam int IDX_W      = 10;
  localparam int COUNT_W    = 11;
  localparam int TOL_W      = 16;
  localparam int COORD_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TRIAL = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_TOL   = 1'b1;

  typedef struct packed {
    action_t                    action;
    logic [IDX_W-1:0]           point_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic [IDX_W-1:0]           sample_b;
    logic [IDX_W-1:0]           sample_c;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [COUNT_W-1:0] inlier_count;
    logic               became_best;
    logic [COUNT_W-1:0] best_count;
    logic               is_inlier;
  } out_result_t;

endpackage

// File: rtl/rpf_point_mem.sv
// rpf_point_mem: point store, one write port and one registered read port.
// Depends on nothing; entries hold packed x, y, z coordinates.
`timescale 1ns / 1ps

module rpf_point_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rpf_dist_pipe.sv
// rpf_dist_pipe: four-stage point-to-plane test, (n.p + D)^2 < R.
// Depends on nothing; plane terms and R come from the sequencer.
`timescale 1ns / 1ps

module rpf_dist_pipe #(
  parameter int CB  = 16,
  parameter int NW  = 35,
  parameter int DW  = 53,
  parameter int RW  = 102
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_skip,
  input  logic signed [CB-1:0] px,
  input  logic signed [CB-1:0] py,
  input  logic signed [CB-1:0] pz,
  input  logic signed [NW-1:0] na,
  input  logic signed [NW-1:0] nb,
  input  logic signed [NW-1:0] nc,
  input  logic signed [DW-1:0] nd,
  input  logic [RW-1:0]        rlim,
  output logic                 hit_valid,
  output logic                 hit
);

  localparam int PW   = NW + CB;
  localparam int SW   = PW + 3;
  localparam int H    = (SW + 1) / 2;
  localparam int QW   = 4 * H;
  localparam int CMPW = (QW > RW) ? QW : RW;

  logic [3:0] v_r;
  logic       skip1_r, skip2_r, skip3_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r;
  logic [SW-1:0]  mag_r;
  logic [2*H-1:0] hh_r, hl_r, ll_r;
  logic           hit_r;

  logic signed [SW-1:0] s_sum;
  logic signed [SW-1:0] s_neg;
  logic [2*H-1:0]       magx;
  logic [QW-1:0]        sq;

  assign s_sum = SW'(pa_r) + SW'(pb_r) + SW'(pc_r) + SW'(nd);
  assign s_neg = -s_sum;
  assign magx  = (2*H)'(mag_r);
  assign sq    = (QW'(hh_r) << (2*H)) + (QW'(hl_r) << (H+1)) + QW'(ll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    pa_r    <= na * px;
    pb_r    <= nb * py;
    pc_r    <= nc * pz;
    skip1_r <= in_skip;
    mag_r   <= s_sum[SW-1] ? s_neg : s_sum;
    skip2_r <= skip1_r;
    hh_r    <= magx[2*H-1:H] * magx[2*H-1:H];
    hl_r    <= magx[2*H-1:H] * magx[H-1:0];
    ll_r    <= magx[H-1:0] * magx[H-1:0];
    skip3_r <= skip2_r;
    hit_r   <= !skip3_r && (CMPW'(sq) < CMPW'(rlim));
  end

  assign hit_valid = v_r[3];
  assign hit       = hit_r;

endmodule

// File: rtl/ransac_plane_fit_3d_unit.sv
// ransac_plane_fit_3d_unit: top level, command port, sequencer and best-plane state.
// Depends on rpf_pkg, rpf_point_mem and rpf_dist_pipe.
//
// Load, clear and rejected items, and queries that need no distance test (no best
// plane yet, or the point is one of its samples), finish at once: the result strobe
// comes the cycle after start and busy never rises. A trial holds busy to fetch the
// samples, run eight setup steps, walk num_points entries (capped at MAX_POINTS) at
// one point per cycle through the store's single read port, drain the four-stage
// distance pipeline and report. A query that tests distance holds busy for the
// last four setup steps and a scan of its point. The result strobe of a busy item
// comes in the same cycle that busy falls. Results appear on out_result for one
// cycle with out_valid; the receiver cannot stall them. cfg_ready is always high.
`timescale 1ns / 1ps

module ransac_plane_fit_3d_unit
  import rpf_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_result_t           out_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CB  = COORD_BITS;
  localparam int LB  = (CB < 16) ? CB : 16;
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int DFW = CB + 1;
  localparam int NW  = 2 * DFW + 1;
  localparam int PW  = NW + CB;
  localparam int DW  = PW + 2;
  localparam int NNW = 2 * NW;
  localparam int NH  = (NNW + 1) / 2;
  localparam int TW  = 2 * TOL_W;
  localparam int RW  = NNW + TW;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_FETCH  = 12'b000000000010,
    ST_DIFF   = 12'b000000000100,
    ST_CROSS  = 12'b000000001000,
    ST_NORM   = 12'b000000010000,
    ST_OFFSET = 12'b000000100000,
    ST_NSQ    = 12'b000001000000,
    ST_NSUM   = 12'b000010000000,
    ST_RMUL   = 12'b000100000000,
    ST_RSUM   = 12'b001000000000,
    ST_SCAN   = 12'b010000000000,
    ST_DONE   = 12'b100000000000
  } state_t;

  function automatic logic signed [CB-1:0] narrow(input logic signed [COORD_W-1:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    w = (w <<< (32 - LB)) >>> (32 - LB);
    return CB'(w);
  endfunction

  state_t state_r, state_nxt;

  logic [10:0]      num_points_r;
  logic [TOL_W-1:0] tol_r;

  action_t          act_r;
  logic [IDX_W-1:0] ia_r, ib_r, ic_r;
  logic [1:0]       fetch_cnt_r;

  logic signed [CB-1:0]      px_r [3];
  logic signed [CB-1:0]      py_r [3];
  logic signed [CB-1:0]      pz_r [3];
  logic signed [DFW-1:0]     u1_r, u2_r, u3_r, v1_r, v2_r, v3_r;
  logic signed [2*DFW-1:0]   m1_r, m2_r, m3_r, m4_r, m5_r, m6_r;
  logic signed [NW-1:0]      a_r, b_r, c_r;
  logic signed [PW-1:0]      oa_r, ob_r, oc_r;
  logic signed [DW-1:0]      d_r;
  logic [NNW-1:0]            sqa_r, sqb_r, sqc_r, nn_r;
  logic [TW-1:0]             t2_r;
  logic [TW+NH-1:0]          rlo_r;
  logic [TW+NNW-NH-1:0]      rhi_r;
  logic [RW-1:0]             r_r;

  logic [AW-1:0] j_r, jlast_r;
  logic          issuing_r;
  logic [2:0]    inflight_r;
  logic [CW-1:0] hits_r;
  logic          rd_val_r, rd_skip_r;

  logic signed [NW-1:0] best_a_r, best_b_r, best_c_r;
  logic signed [DW-1:0] best_d_r;
  logic [IDX_W-1:0]     best_sa_r, best_sb_r, best_sc_r;
  logic [CW-1:0]        best_cnt_r;

  logic        out_valid_r, out_valid_nxt;
  out_result_t out_r, out_nxt;

  logic          accept;
  logic [CW-1:0] np;
  logic          load_ok, trial_ok, query_ok, query_sample;
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [3*CB-1:0] mem_rdata;
  logic          hit_valid, hit;
  logic          scan_done;
  logic [CW-1:0] trial_cnt;
  logic          trial_better;
  logic          issue;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_result = out_r;

  assign np = (32'(num_points_r) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(num_points_r);

  assign load_ok  = 32'(in_item.point_index) < MAX_POINTS;
  assign query_ok = 32'(in_item.point_index) < 32'(np);
  assign trial_ok = query_ok
                 && (32'(in_item.sample_b) < 32'(np))
                 && (32'(in_item.sample_c) < 32'(np))
                 && (in_item.point_index != in_item.sample_b)
                 && (in_item.point_index != in_item.sample_c)
                 && (in_item.sample_b != in_item.sample_c);
  assign query_sample = (best_cnt_r != '0)
                     && ((in_item.point_index == best_sa_r)
                      || (in_item.point_index == best_sb_r)
                      || (in_item.point_index == best_sc_r));

  assign mem_we = accept && (in_item.action == ACT_LOAD) && load_ok;

  always_comb begin
    case (fetch_cnt_r)
      2'd0:    mem_raddr = AW'(ia_r);
      2'd1:    mem_raddr = AW'(ib_r);
      2'd2:    mem_raddr = AW'(ic_r);
      default: mem_raddr = AW'(ic_r);
    endcase
    if (state_r == ST_SCAN) begin
      mem_raddr = j_r;
    end
  end

  assign issue        = (state_r == ST_SCAN) && issuing_r;
  assign scan_done    = (state_r == ST_SCAN) && !issuing_r && (inflight_r == '0);
  assign trial_cnt    = CW'(3) + hits_r;
  assign trial_better = (state_r == ST_DONE) && (act_r == ACT_TRIAL)
                     && (trial_cnt > best_cnt_r);

  rpf_point_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (3 * CB)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_item.point_index)),
    .wdata ({narrow(in_item.coord_x), narrow(in_item.coord_y), narrow(in_item.coord_z)}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rpf_dist_pipe #(
    .CB (CB),
    .NW (NW),
    .DW (DW),
    .RW (RW)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_val_r),
    .in_skip   (rd_skip_r),
    .px        (mem_rdata[3*CB-1:2*CB]),
    .py        (mem_rdata[2*CB-1:CB]),
    .pz        (mem_rdata[CB-1:0]),
    .na        (a_r),
    .nb        (b_r),
    .nc        (c_r),
    .nd        (d_r),
    .rlim      (r_r),
    .hit_valid (hit_valid),
    .hit       (hit)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.action == ACT_TRIAL) && trial_ok) begin
          state_nxt = ST_FETCH;
        end else if (accept && (in_item.action == ACT_QUERY) && query_ok
                     && (best_cnt_r != '0) && !query_sample) begin
          state_nxt = ST_NSQ;
        end
      end
      ST_FETCH:  state_nxt = (fetch_cnt_r == 2'd3) ? ST_DIFF : ST_FETCH;
      ST_DIFF:   state_nxt = ST_CROSS;
      ST_CROSS:  state_nxt = ST_NORM;
      ST_NORM:   state_nxt = ST_OFFSET;
      ST_OFFSET: state_nxt = ST_NSQ;
      ST_NSQ:    state_nxt = ST_NSUM;
      ST_NSUM:   state_nxt = ST_RMUL;
      ST_RMUL:   state_nxt = ST_RSUM;
      ST_RSUM:   state_nxt = ST_SCAN;
      ST_SCAN:   state_nxt = scan_done ? ST_DONE : ST_SCAN;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (accept) begin
      out_nxt.status       = 1'b0;
      out_nxt.inlier_count = '0;
      out_nxt.became_best  = 1'b0;
      out_nxt.best_count   = COUNT_W'(best_cnt_r);
      out_nxt.is_inlier    = 1'b0;
      case (in_item.action)
        ACT_LOAD: begin
          out_nxt.status = !load_ok;
          out_valid_nxt  = 1'b1;
        end
        ACT_TRIAL: begin
          out_nxt.status = !trial_ok;
          out_valid_nxt  = !trial_ok;
        end
        ACT_QUERY: begin
          out_nxt.status    = !query_ok;
          out_nxt.is_inlier = query_ok && query_sample;
          out_valid_nxt     = !(query_ok && (best_cnt_r != '0) && !query_sample);
        end
        ACT_CLEAR: begin
          out_nxt.best_count = '0;
          out_valid_nxt      = 1'b1;
        end
        default: out_valid_nxt = 1'b1;
      endcase
    end
    if (state_r == ST_DONE) begin
      out_valid_nxt = 1'b1;
      if (act_r == ACT_TRIAL) begin
        out_nxt.inlier_count = COUNT_W'(trial_cnt);
        if (trial_better) begin
          out_nxt.became_best = 1'b1;
          out_nxt.best_count  = COUNT_W'(trial_cnt);
        end
      end else begin
        out_nxt.is_inlier = (hits_r != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_points_r <= 11'd1024;
      tol_r        <= 16'd77;
      fetch_cnt_r  <= '0;
      issuing_r    <= 1'b0;
      inflight_r   <= '0;
      rd_val_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      best_cnt_r   <= '0;
      best_a_r     <= '0;
      best_b_r     <= '0;
      best_c_r     <= '0;
      best_d_r     <= '0;
      best_sa_r    <= '0;
      best_sb_r    <= '0;
      best_sc_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_POINTS: num_points_r <= cfg_wdata[10:0];
          CFG_DIST_TOL:   tol_r        <= cfg_wdata;
          default:        tol_r        <= tol_r;
        endcase
      end

      if (state_r == ST_FETCH) begin
        fetch_cnt_r <= fetch_cnt_r + 2'd1;
      end else begin
        fetch_cnt_r <= '0;
      end

      rd_val_r   <= issue;
      inflight_r <= inflight_r + {2'b0, issue} - {2'b0, hit_valid};

      if (state_r == ST_RSUM) begin
        issuing_r <= 1'b1;
      end else if (issue && (j_r == jlast_r)) begin
        issuing_r <= 1'b0;
      end

      if (accept && (in_item.action == ACT_CLEAR)) begin
        best_cnt_r <= '0;
        best_a_r   <= '0;
        best_b_r   <= '0;
        best_c_r   <= '0;
        best_d_r   <= '0;
        best_sa_r  <= '0;
        best_sb_r  <= '0;
        best_sc_r  <= '0;
      end else if (trial_better) begin
        best_cnt_r <= trial_cnt;
        best_a_r   <= a_r;
        best_b_r   <= b_r;
        best_c_r   <= c_r;
        best_d_r   <= d_r;
        best_sa_r  <= ia_r;
        best_sb_r  <= ib_r;
        best_sc_r  <= ic_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_item.action;
      ia_r  <= in_item.point_index;
      ib_r  <= in_item.sample_b;
      ic_r  <= in_item.sample_c;
      a_r   <= best_a_r;
      b_r   <= best_b_r;
      c_r   <= best_c_r;
      d_r   <= best_d_r;
    end

    if ((state_r == ST_FETCH) && (fetch_cnt_r != 2'd0)) begin
      px_r[fetch_cnt_r - 2'd1] <= mem_rdata[3*CB-1:2*CB];
      py_r[fetch_cnt_r - 2'd1] <= mem_rdata[2*CB-1:CB];
      pz_r[fetch_cnt_r - 2'd1] <= mem_rdata[CB-1:0];
    end

    case (state_r)
      ST_DIFF: begin
        u1_r <= DFW'(px_r[1]) - DFW'(px_r[0]);
        u2_r <= DFW'(py_r[1]) - DFW'(py_r[0]);
        u3_r <= DFW'(pz_r[1]) - DFW'(pz_r[0]);
        v1_r <= DFW'(px_r[2]) - DFW'(px_r[0]);
        v2_r <= DFW'(py_r[2]) - DFW'(py_r[0]);
        v3_r <= DFW'(pz_r[2]) - DFW'(pz_r[0]);
      end
      ST_CROSS: begin
        m1_r <= u2_r * v3_r;
        m2_r <= u3_r * v2_r;
        m3_r <= u3_r * v1_r;
        m4_r <= u1_r * v3_r;
        m5_r <= u1_r * v2_r;
        m6_r <= u2_r * v1_r;
      end
      ST_NORM: begin
        a_r <= NW'(m1_r) - NW'(m2_r);
        b_r <= NW'(m3_r) - NW'(m4_r);
        c_r <= NW'(m5_r) - NW'(m6_r);
      end
      ST_OFFSET: begin
        oa_r <= a_r * px_r[0];
        ob_r <= b_r * py_r[0];
        oc_r <= c_r * pz_r[0];
      end
      ST_NSQ: begin
        if (act_r == ACT_TRIAL) begin
          d_r <= -(DW'(oa_r) + DW'(ob_r) + DW'(oc_r));
        end
        sqa_r <= a_r * a_r;
        sqb_r <= b_r * b_r;
        sqc_r <= c_r * c_r;
        t2_r  <= TW'(tol_r) * TW'(tol_r);
      end
      ST_NSUM: begin
        nn_r <= sqa_r + sqb_r + sqc_r;
      end
      ST_RMUL: begin
        rlo_r <= (TW+NH)'(t2_r) * (TW+NH)'(nn_r[NH-1:0]);
        rhi_r <= (TW+NNW-NH)'(t2_r) * (TW+NNW-NH)'(nn_r[NNW-1:NH]);
      end
      ST_RSUM: begin
        r_r     <= RW'(rlo_r) + (RW'(rhi_r) << NH);
        hits_r  <= '0;
        j_r     <= (act_r == ACT_TRIAL) ? '0 : AW'(ia_r);
        jlast_r <= (act_r == ACT_TRIAL) ? AW'(np - CW'(1)) : AW'(ia_r);
      end
      default: begin
        hits_r <= hits_r + CW'(hit_valid && hit);
      end
    endcase

    if (issue) begin
      j_r       <= j_r + AW'(1);
      rd_skip_r <= (act_r == ACT_TRIAL)
                && ((32'(j_r) == 32'(ia_r)) || (32'(j_r) == 32'(ib_r))
                 || (32'(j_r) == 32'(ic_r)));
    end
  end

endmodule

// File: rtl/rpf_checker.sv
// rpf_checker: port-level assertions for ransac_plane_fit_3d_unit, and its bind.
// Depends on rpf_pkg.
`timescale 1ns / 1ps

module rpf_checker
  import rpf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input out_result_t out_result
);

  a_best_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.became_best |->
      !out_result.status && (out_result.best_count == out_result.inlier_count))
    else $error("became_best with inconsistent counts or bad status");

  a_inlier_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.is_inlier |->
      !out_result.status && (out_result.inlier_count == '0) && !out_result.became_best)
    else $error("is_inlier set on a non-query transaction");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted transaction neither answered nor in progress");

  a_done_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

endmodule

bind ransac_plane_fit_3d_unit rpf_checker u_rpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result)
);

// File: verif/rpf_plane_checker.sv
// rpf_plane_checker: watches the command, result and register channels of the
// plane fit unit, predicts each result and compares it field by field.
// Depends on rpf_pkg; instantiated next to the unit by ransac_plane_fit_3d_unit_tb.
`timescale 1ns / 1ps

module rpf_plane_checker
  import rpf_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  out_result_t           out_result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  int          pt_x [MAX_POINTS];
  int          pt_y [MAX_POINTS];
  int          pt_z [MAX_POINTS];
  int unsigned point_limit;
  int unsigned tol;
  longint      plane_a, plane_b, plane_c, plane_d;
  int unsigned plane_s0, plane_s1, plane_s2;
  int unsigned plane_inliers;
  out_result_t result_q[$];

  function automatic logic [127:0] abs_wide(longint v);
    logic [63:0] r;
    r = v;
    return {64'd0, (v < 0) ? (~r + 64'd1) : r};
  endfunction

  function automatic bit on_plane(longint a, longint b, longint c, longint d, int idx);
    longint       s;
    logic [127:0] ms, ma, mb, mc, lhs, nrm, t2;
    if (a == 0 && b == 0 && c == 0) return 1'b0;
    s   = a * pt_x[idx] + b * pt_y[idx] + c * pt_z[idx] + d;
    ms  = abs_wide(s);
    ma  = abs_wide(a);
    mb  = abs_wide(b);
    mc  = abs_wide(c);
    lhs = ms * ms;
    nrm = ma * ma + mb * mb + mc * mc;
    t2  = 128'(tol) * 128'(tol);
    return lhs < t2 * nrm;
  endfunction

  function automatic out_result_t fit_step(in_item_t it);
    out_result_t r;
    int unsigned np, ia, ib, ic, j, cnt;
    longint      u1, u2, u3, v1, v2, v3, a, b, c, d;
    r  = '0;
    np = (point_limit > MAX_POINTS) ? MAX_POINTS : point_limit;
    ia = it.point_index;
    ib = it.sample_b;
    ic = it.sample_c;
    case (it.action)
      ACT_LOAD: begin
        if (ia >= MAX_POINTS) begin
          r.status = 1'b1;
        end else begin
          pt_x[ia] = it.coord_x;
          pt_y[ia] = it.coord_y;
          pt_z[ia] = it.coord_z;
        end
      end
      ACT_TRIAL: begin
        if (ia >= np || ib >= np || ic >= np || ia == ib || ia == ic || ib == ic) begin
          r.status = 1'b1;
        end else begin
          u1 = longint'(pt_x[ib]) - pt_x[ia];
          u2 = longint'(pt_y[ib]) - pt_y[ia];
          u3 = longint'(pt_z[ib]) - pt_z[ia];
          v1 = longint'(pt_x[ic]) - pt_x[ia];
          v2 = longint'(pt_y[ic]) - pt_y[ia];
          v3 = longint'(pt_z[ic]) - pt_z[ia];
          a  = u2 * v3 - u3 * v2;
          b  = u3 * v1 - u1 * v3;
          c  = u1 * v2 - u2 * v1;
          d  = -(a * pt_x[ia] + b * pt_y[ia] + c * pt_z[ia]);
          cnt = 3;
          for (j = 0; j < np; j++) begin
            if (j != ia && j != ib && j != ic && on_plane(a, b, c, d, j)) cnt++;
          end
          r.inlier_count = cnt;
          if (cnt > plane_inliers) begin
            r.became_best = 1'b1;
            plane_inliers = cnt;
            plane_a = a;
            plane_b = b;
            plane_c = c;
            plane_d = d;
            plane_s0 = ia;
            plane_s1 = ib;
            plane_s2 = ic;
          end
        end
      end
      ACT_QUERY: begin
        if (ia >= np) begin
          r.status = 1'b1;
        end else if (plane_inliers != 0) begin
          if (ia == plane_s0 || ia == plane_s1 || ia == plane_s2) r.is_inlier = 1'b1;
          else r.is_inlier = on_plane(plane_a, plane_b, plane_c, plane_d, ia);
        end
      end
      default: begin
        plane_a = 0;
        plane_b = 0;
        plane_c = 0;
        plane_d = 0;
        plane_s0 = 0;
        plane_s1 = 0;
        plane_s2 = 0;
        plane_inliers = 0;
      end
    endcase
    r.best_count = plane_inliers;
    return r;
  endfunction

  always @(posedge clk) begin
    out_result_t exp_r;
    if (!rst_n) begin
      point_limit <= 1024;
      tol <= 77;
      plane_a = 0;
      plane_b = 0;
      plane_c = 0;
      plane_d = 0;
      plane_s0 = 0;
      plane_s1 = 0;
      plane_s2 = 0;
      plane_inliers = 0;
      result_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r !== out_result) begin
            fail_count <= fail_count + 1;
            if (exp_r.status !== out_result.status)
              $error("status exp %0d act %0d", exp_r.status, out_result.status);
            if (exp_r.inlier_count !== out_result.inlier_count)
              $error("inlier_count exp %0d act %0d", exp_r.inlier_count,
                     out_result.inlier_count);
            if (exp_r.became_best !== out_result.became_best)
              $error("became_best exp %0d act %0d", exp_r.became_best,
                     out_result.became_best);
            if (exp_r.best_count !== out_result.best_count)
              $error("best_count exp %0d act %0d", exp_r.best_count, out_result.best_count);
            if (exp_r.is_inlier !== out_result.is_inlier)
              $error("is_inlier exp %0d act %0d", exp_r.is_inlier, out_result.is_inlier);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NUM_POINTS) point_limit <= cfg_wdata & 16'h07FF;
        else if (cfg_index == CFG_DIST_TOL) tol <= cfg_wdata;
      end
      if (start && !busy) result_q = {result_q, fit_step(in_item)};
      pending <= result_q.size();
    end
  end

endmodule

// File: verif/ransac_plane_fit_3d_unit_tb.sv
// ransac_plane_fit_3d_unit_tb: stimulus and verdict for the plane fit unit.
// Depends on rpf_pkg, the unit and rpf_plane_checker, which checks every result.
`timescale 1ns / 1ps

module ransac_plane_fit_3d_unit_tb;
  import rpf_pkg::*;

  localparam int MAX_PTS   = 1024;
  localparam int CYC_LIMIT = 500000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_valid;
  out_result_t           out_result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  bit          loaded [MAX_PTS];
  int unsigned cur_np;
  bit          gaps_on;
  int          n_items, n_trials;
  int          cycles;

  ransac_plane_fit_3d_unit u_dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  rpf_plane_checker #(.MAX_POINTS(MAX_PTS)) u_checker (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata, .fail_count, .pending
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("ransac_plane_fit_3d_unit test failed");
      $finish;
    end
  end

  function automatic in_item_t mk(action_t act, int idx, int x, int y, int z, int b, int c);
    in_item_t it;
    it.action      = act;
    it.point_index = idx;
    it.coord_x     = x;
    it.coord_y     = y;
    it.coord_z     = z;
    it.sample_b    = b;
    it.sample_c    = c;
    return it;
  endfunction

  function automatic int rnd16();
    return int'($signed(16'($urandom)));
  endfunction

  task automatic send(in_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    if (it.action == ACT_LOAD) loaded[it.point_index] = 1'b1;
    if (it.action == ACT_TRIAL) n_trials++;
    n_items++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // points near a tilted plane, with some scattered outliers
  task automatic load_point(int idx);
    int x, y;
    x = $signed($urandom_range(0, 16000)) - 8000;
    y = $signed($urandom_range(0, 16000)) - 8000;
    if ($urandom_range(0, 4) == 0)
      send(mk(ACT_LOAD, idx, rnd16(), rnd16(), rnd16(), $urandom, $urandom));
    else
      send(mk(ACT_LOAD, idx, x, y, (x >>> 2) - (y >>> 3) + $urandom_range(0, 60) - 30,
              $urandom, $urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int unsigned cnt;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_NUM_POINTS) begin
      cnt = val & 16'h07FF;
      cur_np = (cnt > MAX_PTS) ? MAX_PTS : cnt;
    end
  endtask

  // set the point count only after every point it covers is loaded
  task automatic set_points(int unsigned val, int unsigned tol_val);
    int unsigned lim;
    lim = (val > MAX_PTS) ? MAX_PTS : val;
    for (int i = 0; i < lim; i++) if (!loaded[i]) load_point(i);
    drain();
    write_reg(CFG_NUM_POINTS, val);
    write_reg(CFG_DIST_TOL, tol_val);
  endtask

  task automatic run_random(int count);
    int r, a, b, c;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        load_point($urandom_range(0, MAX_PTS - 1));
      end else if (r < 70) begin
        a = $urandom_range(0, cur_np - 1);
        do b = $urandom_range(0, cur_np - 1); while (b == a);
        do c = $urandom_range(0, cur_np - 1); while (c == a || c == b);
        if ($urandom_range(0, 6) == 0) begin
          case ($urandom_range(0, 2))
            0: b = a;
            1: c = b;
            default: c = $urandom_range(0, MAX_PTS - 1);
          endcase
        end
        send(mk(ACT_TRIAL, a, rnd16(), rnd16(), rnd16(), b, c));
      end else if (r < 93) begin
        a = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_PTS - 1)
                                        : $urandom_range(0, cur_np - 1);
        send(mk(ACT_QUERY, a, rnd16(), rnd16(), rnd16(), $urandom, $urandom));
      end else begin
        send(mk(ACT_CLEAR, $urandom, rnd16(), rnd16(), rnd16(), $urandom, $urandom));
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cycles    = 0;
    gaps_on   = 1'b1;
    n_items   = 0;
    n_trials  = 0;
    cur_np    = MAX_PTS;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_NUM_POINTS, 16'd6);
    write_reg(CFG_DIST_TOL, 16'd77);
    send(mk(ACT_LOAD, 0, -32768, -32768, 0, 0, 0));
    send(mk(ACT_LOAD, 1, 32767, -32768, 0, 1023, 1023));
    send(mk(ACT_LOAD, 2, -32768, 32767, 32767, 0, 0));
    send(mk(ACT_LOAD, 3, 0, 0, 0, 0, 0));
    send(mk(ACT_LOAD, 4, 256, 256, 256, 0, 0));
    send(mk(ACT_LOAD, 5, 512, 512, 512, 0, 0));
    send(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_QUERY, 1023, 0, 0, 0, 0, 0));
    send(mk(ACT_TRIAL, 0, 0, 0, 0, 0, 1));
    send(mk(ACT_TRIAL, 0, 0, 0, 0, 1, 1023));
    send(mk(ACT_TRIAL, 3, 0, 0, 0, 4, 5));
    send(mk(ACT_QUERY, 4, 0, 0, 0, 0, 0));
    send(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_TRIAL, 0, 0, 0, 0, 1, 2));
    send(mk(ACT_TRIAL, 0, 0, 0, 0, 3, 4));
    send(mk(ACT_QUERY, 5, 0, 0, 0, 0, 0));
    send(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_TRIAL, 2, 0, 0, 0, 1, 0));
    drain();
    write_reg(CFG_NUM_POINTS, 16'd3);
    send(mk(ACT_TRIAL, 0, 0, 0, 0, 1, 2));
    send(mk(ACT_TRIAL, 0, 0, 0, 0, 1, 3));
    send(mk(ACT_QUERY, 2, 0, 0, 0, 0, 0));
    send(mk(ACT_QUERY, 3, 0, 0, 0, 0, 0));

    set_points(16, $urandom_range(40, 400));
    run_random(100);
    set_points(64, 0);
    run_random(80);
    set_points(200, 16'hFFFF);
    run_random(60);
    set_points(40, $urandom_range(20, 2000));
    gaps_on = 1'b0;
    run_random(130);
    drain();

    $display("ran %0d transactions, %0d of them trials, over point counts 3 to 200",
             n_items, n_trials);
    $display("with distance tolerances from 0 to 65535 and idle bursts on the sender");
    if (fail_count == 0) begin
      $display("ransac_plane_fit_3d_unit test passed");
    end else begin
      $display("ransac_plane_fit_3d_unit test failed");
    end
    $finish;
  end

endmodule

// File: ransac_plane_fit_3d_unit.f
rtl/rpf_pkg.sv
rtl/rpf_point_mem.sv
rtl/rpf_dist_pipe.sv
rtl/ransac_plane_fit_3d_unit.sv
rtl/rpf_checker.sv
verif/rpf_plane_checker.sv
verif/ransac_plane_fit_3d_unit_tb.sv
